>>> rtl/lobm_pkg.sv
// Shared types, constants and helpers of the limit order book matcher.
package lobm_pkg;

  localparam int MAX_ORDERS = 64;
  localparam int IDX_W      = $clog2(MAX_ORDERS);
  localparam int CNT_W      = $clog2(MAX_ORDERS + 1);
  localparam int ID_WIDTH   = 32;
  localparam logic [31:0] ID_MASK = 32'hFFFF_FFFF >> (32 - ID_WIDTH);

  localparam logic [1:0] OP_LIMIT  = 2'd0;
  localparam logic [1:0] OP_MARKET = 2'd1;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_SETREM = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_PARTIAL  = 3'd1;
  localparam logic [2:0] ST_FILLED   = 3'd2;
  localparam logic [2:0] ST_MKT_CXL  = 3'd3;
  localparam logic [2:0] ST_CXL_DONE = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  typedef struct packed {
    logic             found;
    logic [31:0]      price;
    logic [31:0]      arrival;
    logic [31:0]      remaining;
    logic [31:0]      id;
    logic [IDX_W-1:0] idx;
  } best_t;

  typedef struct packed {
    best_t            bid;
    best_t            ask;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } carry_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] idx;
    logic             side;
    logic [31:0]      price;
    logic [31:0]      remaining;
    logic [31:0]      id;
    logic [31:0]      arrival;
  } cmd_t;

  typedef struct packed {
    logic        tv;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] tid;
  } res_t;

  // True when arrival a came before arrival b, modulo 2^32.
  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

>>> rtl/lobm_cell.sv
// One resting-order slot of the book and its stage of the search chain.
module lobm_cell import lobm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  cmd_t             cmd,
  input  logic [31:0]      cancel_id,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  logic        valid_r;
  logic        side_r;
  logic [31:0] price_r;
  logic [31:0] rem_r;
  logic [31:0] id_r;
  logic [31:0] arr_r;
  carry_t      carry_r;
  carry_t      carry_nxt;
  logic        sel;

  assign sel = (cmd.kind != CMD_NONE) && (cmd.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (sel) begin
      case (cmd.kind)
        CMD_LOAD:   valid_r <= 1'b1;
        CMD_SETREM: valid_r <= (cmd.remaining != 32'd0);
        CMD_CLEAR:  valid_r <= 1'b0;
        default:    valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.kind == CMD_LOAD) begin
      side_r  <= cmd.side;
      price_r <= cmd.price;
      id_r    <= cmd.id;
      arr_r   <= cmd.arrival;
    end
    if (sel && (cmd.kind == CMD_LOAD || cmd.kind == CMD_SETREM)) begin
      rem_r <= cmd.remaining;
    end
    carry_r <= carry_nxt;
  end

  // Merge this slot into the running best, match and free-slot results.
  always_comb begin
    carry_nxt = carry_in;
    if (valid_r && !side_r) begin
      if (!carry_in.bid.found || price_r > carry_in.bid.price ||
          (price_r == carry_in.bid.price && earlier(arr_r, carry_in.bid.arrival))) begin
        carry_nxt.bid = '{1'b1, price_r, arr_r, rem_r, id_r, cell_idx};
      end
    end
    if (valid_r && side_r) begin
      if (!carry_in.ask.found || price_r < carry_in.ask.price ||
          (price_r == carry_in.ask.price && earlier(arr_r, carry_in.ask.arrival))) begin
        carry_nxt.ask = '{1'b1, price_r, arr_r, rem_r, id_r, cell_idx};
      end
    end
    if (!carry_in.hit_found && valid_r && id_r == cancel_id) begin
      carry_nxt.hit_found = 1'b1;
      carry_nxt.hit_idx   = cell_idx;
    end
    if (!carry_in.free_found && !valid_r) begin
      carry_nxt.free_found = 1'b1;
      carry_nxt.free_idx   = cell_idx;
    end
  end

  assign carry_out = carry_r;

endmodule

>>> rtl/limit_order_book_matcher.sv
// Price-time priority limit order book: a chain of slot cells plus the matching sequencer.
// Each search is one pass of the cell chain. An item that makes T trades takes T + 2
// searches, then each result is emitted through the read, load and output states and
// may wait there on an output stall; one item is handled at a time.
// Reset (rst_n low, synchronous) empties the book and clears the order, trade and
// arrival counters; no clearing pass is needed, slot valid bits reset at once.
module limit_order_book_matcher import lobm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic        in_side,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  input  logic [31:0] in_cancel_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_trade_valid,
  output logic [31:0] out_trade_price,
  output logic [31:0] out_trade_quantity,
  output logic [31:0] out_buy_order_id,
  output logic [31:0] out_sell_order_id,
  output logic [31:0] out_trade_id,
  output logic [31:0] out_order_id,
  output logic [2:0]  out_status,
  output logic        out_last,
  output logic [31:0] out_best_bid,
  output logic [31:0] out_best_ask
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_LD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // The cell chain. Every cell re-evaluates each cycle, so once the book and the
  // cancel id have been steady for a full pass the tail carries the answers.
  carry_t carry [MAX_ORDERS+1];
  cmd_t   cmd;
  carry_t res;

  assign carry[0] = '0;
  assign res      = carry[MAX_ORDERS];

  logic [31:0] cid_r, cid_nxt;

  for (genvar g = 0; g < MAX_ORDERS; g++) begin : g_cell
    lobm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cmd),
      .cancel_id (cid_r),
      .carry_in  (carry[g]),
      .carry_out (carry[g+1])
    );
  end

  // Sequencer registers.
  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             side_r, side_nxt;
  logic [31:0]      price_r, price_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      oid_r, oid_nxt;
  logic [31:0]      order_num_r, order_num_nxt;
  logic [31:0]      trade_num_r, trade_num_nxt;
  logic [31:0]      arr_num_r, arr_num_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [2:0]       status_r, status_nxt;
  logic             final_r, final_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [31:0]      bid_r, bid_nxt;
  logic [31:0]      ask_r, ask_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_r, last_nxt;

  // Result buffer: trades are held until the item ends, because every result
  // reports the best bid and ask as they stand after the whole item.
  res_t             rbuf [MAX_ORDERS];
  res_t             rbuf_q;
  res_t             wr_data;
  logic             wr_en;
  res_t             out_q;

  best_t       opp;
  logic        market;
  logic        crosses;
  logic [31:0] exec_qty;

  assign opp      = side_r ? res.bid : res.ask;
  assign market   = (op_r == OP_MARKET);
  assign crosses  = side_r ? (opp.price >= price_r) : (opp.price <= price_r);
  assign exec_qty = (rem_r < opp.remaining) ? rem_r : opp.remaining;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    side_nxt      = side_r;
    price_nxt     = price_r;
    rem_nxt       = rem_r;
    cid_nxt       = cid_r;
    oid_nxt       = oid_r;
    order_num_nxt = order_num_r;
    trade_num_nxt = trade_num_r;
    arr_num_nxt   = arr_num_r;
    n_nxt         = n_r;
    status_nxt    = status_r;
    final_nxt     = final_r;
    rd_nxt        = rd_r;
    bid_nxt       = bid_r;
    ask_nxt       = ask_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    cmd           = '0;
    cmd.kind      = CMD_NONE;
    wr_en         = 1'b0;
    wr_data       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          side_nxt  = in_side;
          price_nxt = in_price;
          rem_nxt   = in_quantity;
          cid_nxt   = in_cancel_id;
          n_nxt     = '0;
          final_nxt = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
          if (in_opcode[1]) begin
            oid_nxt = '0;
          end else begin
            order_num_nxt = order_num_r + 32'd1;
            oid_nxt       = (order_num_r + 32'd1) & ID_MASK;
            arr_num_nxt   = arr_num_r + 32'd1;
          end
        end
      end

      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(MAX_ORDERS - 1)) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        cnt_nxt   = '0;
        state_nxt = S_SCAN;
        if (final_r) begin
          // Book is settled: capture the top of book and start emitting.
          bid_nxt   = res.bid.found ? res.bid.price : 32'd0;
          ask_nxt   = res.ask.found ? res.ask.price : 32'hFFFF_FFFF;
          rd_nxt    = '0;
          state_nxt = S_RD;
        end else if (op_r[1]) begin
          if (res.hit_found) begin
            cmd.kind   = CMD_CLEAR;
            cmd.idx    = res.hit_idx;
            status_nxt = ST_CXL_DONE;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
          wr_en     = 1'b1;
          n_nxt     = CNT_W'(1);
          final_nxt = 1'b1;
        end else if (rem_r != 32'd0 && n_r < CNT_W'(MAX_ORDERS) && opp.found &&
                     (market || crosses)) begin
          // One trade against the best opposite slot.
          cmd.kind         = CMD_SETREM;
          cmd.idx          = opp.idx;
          cmd.remaining    = opp.remaining - exec_qty;
          wr_en            = 1'b1;
          wr_data.tv       = 1'b1;
          wr_data.price    = opp.price;
          wr_data.qty      = exec_qty;
          wr_data.buy_id   = side_r ? opp.id : oid_r;
          wr_data.sell_id  = side_r ? oid_r : opp.id;
          wr_data.tid      = trade_num_r + 32'd1;
          trade_num_nxt    = trade_num_r + 32'd1;
          rem_nxt          = rem_r - exec_qty;
          n_nxt            = n_r + 1'b1;
        end else begin
          if (rem_r == 32'd0) begin
            status_nxt = ST_FILLED;
          end else if (market) begin
            status_nxt = (n_r == '0) ? ST_MKT_CXL : ST_PARTIAL;
          end else if (res.free_found) begin
            cmd.kind      = CMD_LOAD;
            cmd.idx       = res.free_idx;
            cmd.side      = side_r;
            cmd.price     = price_r;
            cmd.remaining = rem_r;
            cmd.id        = oid_r;
            cmd.arrival   = arr_num_r;
            status_nxt    = (n_r == '0) ? ST_NEW : ST_PARTIAL;
          end else begin
            status_nxt = ST_FULL;
          end
          if (n_r == '0) begin
            wr_en = 1'b1;
            n_nxt = CNT_W'(1);
          end
          final_nxt = 1'b1;
        end
      end

      S_RD: begin
        state_nxt = S_LD;
      end

      S_LD: begin
        out_valid_nxt = 1'b1;
        last_nxt      = ({1'b0, rd_r} == n_r - 1'b1);
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_nxt    = rd_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_num_r <= '0;
      trade_num_r <= '0;
      arr_num_r   <= '0;
      out_valid_r <= 1'b0;
      final_r     <= 1'b0;
      n_r         <= '0;
      cnt_r       <= '0;
      rd_r        <= '0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      order_num_r <= order_num_nxt;
      trade_num_r <= trade_num_nxt;
      arr_num_r   <= arr_num_nxt;
      out_valid_r <= out_valid_nxt;
      final_r     <= final_nxt;
      n_r         <= n_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    side_r   <= side_nxt;
    price_r  <= price_nxt;
    rem_r    <= rem_nxt;
    cid_r    <= cid_nxt;
    oid_r    <= oid_nxt;
    status_r <= status_nxt;
    bid_r    <= bid_nxt;
    ask_r    <= ask_nxt;
  end

  // Result buffer port: one write while matching, one registered read while emitting.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rbuf[n_r[IDX_W-1:0]] <= wr_data;
    end
    if (state_r == S_RD) begin
      rbuf_q <= rbuf[rd_r];
    end
    if (state_r == S_LD) begin
      out_q <= rbuf_q;
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_trade_valid    = out_q.tv;
  assign out_trade_price    = out_q.price;
  assign out_trade_quantity = out_q.qty;
  assign out_buy_order_id   = out_q.buy_id;
  assign out_sell_order_id  = out_q.sell_id;
  assign out_trade_id       = out_q.tid;
  assign out_order_id       = oid_r;
  assign out_status         = last_r ? status_r : ST_NEW;
  assign out_last           = last_r;
  assign out_best_bid       = bid_r;
  assign out_best_ask       = ask_r;

  // After the final transaction of an item the block is ready for the next one.
  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after last result");

  // Input and output sides are never open together in this sequential design.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  // Only the final result of an item carries a nonzero status.
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_NEW)
    else $error("status on a non-final result");

endmodule

>>> dv/tb_limit_order_book_matcher.sv
// Self-checking testbench of the price-time priority limit order book matcher.
`timescale 1ns / 1ps

module tb_limit_order_book_matcher;
  import lobm_pkg::*;

  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_CANCEL_ALT = 2'd3;
  localparam int BOOK_SLOTS = MAX_ORDERS;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_opcode;
  logic        in_side;
  logic [31:0] in_price;
  logic [31:0] in_quantity;
  logic [31:0] in_cancel_id;
  logic        out_valid;
  logic        out_ready;
  logic        out_trade_valid;
  logic [31:0] out_trade_price;
  logic [31:0] out_trade_quantity;
  logic [31:0] out_buy_order_id;
  logic [31:0] out_sell_order_id;
  logic [31:0] out_trade_id;
  logic [31:0] out_order_id;
  logic [2:0]  out_status;
  logic        out_last;
  logic [31:0] out_best_bid;
  logic [31:0] out_best_ask;

  limit_order_book_matcher dut (.*);

  // One expected result transaction.
  typedef struct packed {
    logic        trade_valid;
    logic [31:0] exec_price;
    logic [31:0] trade_quantity;
    logic [31:0] buy_id;
    logic [31:0] sell_id;
    logic [31:0] trade_id;
    logic [31:0] taker_id;
    logic [2:0]  status;
    logic        last;
    logic [31:0] top_bid;
    logic [31:0] top_ask;
  } fill_t;

  // The testbench's own copy of the book.
  logic [31:0] book_price   [BOOK_SLOTS];
  logic [31:0] book_left    [BOOK_SLOTS];
  logic [31:0] book_id      [BOOK_SLOTS];
  logic [31:0] book_arrival [BOOK_SLOTS];
  logic        book_live    [BOOK_SLOTS];
  logic        book_side    [BOOK_SLOTS];
  logic [31:0] orders_seen;
  logic [31:0] trade_count;
  logic [31:0] arrival_count;

  fill_t expected_fills[$];
  int    error_count;
  int    idle_pct_in;
  int    idle_pct_out;
  bit    hold_out;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Best live entry on one side, or -1 when that side is empty.
  function automatic int best_entry(input logic side);
    int best;
    logic tighter;
    best = -1;
    for (int i = 0; i < BOOK_SLOTS; i++) begin
      if (book_live[i] && book_side[i] == side) begin
        if (best < 0) begin
          best = i;
        end else begin
          tighter = (side == 1'b0) ? (book_price[i] > book_price[best])
                                    : (book_price[i] < book_price[best]);
          if (tighter || (book_price[i] == book_price[best] &&
                          ((book_arrival[i] - book_arrival[best]) >> 31))) begin
            best = i;
          end
        end
      end
    end
    return best;
  endfunction

  // Applies one order to the book copy and queues the results it must cause.
  task automatic match_order(input logic [1:0] opcode, input logic side,
                             input logic [31:0] price, input logic [31:0] qty,
                             input logic [31:0] cxl_id);
    fill_t       fills[$];
    fill_t       f;
    logic [31:0] left;
    logic [31:0] oid;
    logic [31:0] exec;
    logic [2:0]  status;
    int          b;
    int          free_slot;
    bit          is_market;
    fills = {};
    if (opcode[1]) begin
      // Both cancel encodings only look at the upper opcode bit.
      status = ST_NOTFOUND;
      for (int i = 0; i < BOOK_SLOTS; i++) begin
        if (status == ST_NOTFOUND && book_live[i] && book_id[i] == cxl_id) begin
          book_live[i] = 1'b0;
          status = ST_CXL_DONE;
        end
      end
      f = '0;
      fills = {fills, f};
    end else begin
      is_market = (opcode == OP_MARKET);
      left = qty;
      orders_seen++;
      oid = orders_seen & ID_MASK;
      arrival_count++;
      forever begin
        if (left == 0 || fills.size() >= BOOK_SLOTS) break;
        b = best_entry(~side);
        if (b < 0) break;
        if (!is_market && (side == 1'b0 ? book_price[b] > price : book_price[b] < price)) break;
        exec = (left < book_left[b]) ? left : book_left[b];
        left -= exec;
        book_left[b] -= exec;
        trade_count++;
        f = '0;
        f.trade_valid = 1'b1;
        f.exec_price = book_price[b];
        f.trade_quantity = exec;
        f.buy_id = side ? book_id[b] : oid;
        f.sell_id = side ? oid : book_id[b];
        f.trade_id = trade_count;
        f.taker_id = oid;
        fills = {fills, f};
        if (book_left[b] == 0) book_live[b] = 1'b0;
      end
      if (left == 0) begin
        status = ST_FILLED;
      end else if (is_market) begin
        status = (fills.size() == 0) ? ST_MKT_CXL : ST_PARTIAL;
      end else begin
        free_slot = -1;
        for (int i = BOOK_SLOTS - 1; i >= 0; i--) begin
          if (!book_live[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          status = ST_FULL;
        end else begin
          book_price[free_slot] = price;
          book_left[free_slot] = left;
          book_id[free_slot] = oid;
          book_arrival[free_slot] = arrival_count;
          book_live[free_slot] = 1'b1;
          book_side[free_slot] = side;
          status = (fills.size() == 0) ? ST_NEW : ST_PARTIAL;
        end
      end
      if (fills.size() == 0) begin
        f = '0;
        f.taker_id = oid;
        fills = {fills, f};
      end
    end
    b = best_entry(1'b0);
    free_slot = best_entry(1'b1);
    foreach (fills[k]) begin
      fills[k].top_bid = (b < 0) ? 32'd0 : book_price[b];
      fills[k].top_ask = (free_slot < 0) ? 32'hFFFF_FFFF : book_price[free_slot];
    end
    fills[fills.size()-1].status = status;
    fills[fills.size()-1].last = 1'b1;
    foreach (fills[k]) expected_fills = {expected_fills, fills[k]};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Sends one order transaction, with a random idle gap first, and predicts it.
  // Valid stays high after acceptance until the next idle cycle or drain.
  task automatic send_order(input logic [1:0] opcode, input logic side,
                            input logic [31:0] price, input logic [31:0] qty,
                            input logic [31:0] cxl_id);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= opcode;
    in_side      <= side;
    in_price     <= price;
    in_quantity  <= qty;
    in_cancel_id <= cxl_id;
    do @(posedge clk); while (!in_ready);
    match_order(opcode, side, price, qty, cxl_id);
  endtask

  // Result checker: compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    fill_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_fills.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        w = expected_fills[0];
        expected_fills.delete(0);
        if (out_trade_valid !== w.trade_valid)
          report_mismatch("trade valid", 32'(out_trade_valid), 32'(w.trade_valid));
        if (out_trade_price !== w.exec_price)
          report_mismatch("trade px", out_trade_price, w.exec_price);
        if (out_trade_quantity !== w.trade_quantity)
          report_mismatch("trade_quantity", out_trade_quantity, w.trade_quantity);
        if (out_buy_order_id !== w.buy_id) report_mismatch("buyer id", out_buy_order_id, w.buy_id);
        if (out_sell_order_id !== w.sell_id)
          report_mismatch("seller id", out_sell_order_id, w.sell_id);
        if (out_trade_id !== w.trade_id) report_mismatch("trade_id", out_trade_id, w.trade_id);
        if (out_order_id !== w.taker_id) report_mismatch("taker id", out_order_id, w.taker_id);
        if (out_status !== w.status) report_mismatch("status", 32'(out_status), 32'(w.status));
        if (out_last !== w.last) report_mismatch("last", 32'(out_last), 32'(w.last));
        if (out_best_bid !== w.top_bid) report_mismatch("top bid", out_best_bid, w.top_bid);
        if (out_best_ask !== w.top_ask) report_mismatch("top ask", out_best_ask, w.top_ask);
      end
    end
  end

  // Receiver: random stalls, or a full hold-off while the pressure test runs.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_out && ($urandom_range(99) >= idle_pct_out);
  end

  // Random order; prices mostly sit in a narrow band so that books cross often.
  task automatic send_random_order();
    int          pick;
    logic [31:0] px;
    logic [31:0] qty;
    pick = $urandom_range(99);
    px = 32'd1000 + $urandom_range(20);
    if ($urandom_range(19) == 0) px = $urandom_range(32'hFFFF_FFFE, 1);
    qty = $urandom_range(50, 1);
    if ($urandom_range(29) == 0) qty = $urandom();
    if (pick < 60) send_order(OP_LIMIT, 1'($urandom_range(1)), px, qty, $urandom());
    else if (pick < 75) send_order(OP_MARKET, 1'($urandom_range(1)), $urandom(), qty, $urandom());
    else if (pick < 95) send_order($urandom_range(1) ? OP_CANCEL : OP_CANCEL_ALT,
                                   1'($urandom_range(1)), $urandom(), $urandom(),
                                   orders_seen - $urandom_range(10));
    else send_order(OP_CANCEL, 1'b0, 32'd0, 32'd0, $urandom());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_fills.size() != 0) @(posedge clk);
  endtask

  // Field extremes, every opcode, zero quantity, cancel misses, time priority.
  task automatic test_directed();
    send_order(OP_MARKET, 1'b0, 32'd0, 32'd10, 32'd0);
    send_order(OP_LIMIT, 1'b0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(OP_LIMIT, 1'b1, 32'hFFFF_FFFE, 32'd5, 32'd0);
    send_order(OP_LIMIT, 1'b1, 32'd100, 32'd7, 32'd0);
    send_order(OP_LIMIT, 1'b1, 32'd100, 32'd3, 32'd0);
    send_order(OP_LIMIT, 1'b0, 32'd50, 32'd4, 32'd0);
    send_order(OP_LIMIT, 1'b0, 32'd200, 32'd9, 32'd0);
    send_order(OP_MARKET, 1'b0, 32'hFFFF_FFFF, 32'd20, 32'd0);
    send_order(OP_MARKET, 1'b1, 32'd0, 32'd6, 32'd0);
    send_order(OP_LIMIT, 1'b0, 32'd10, 32'd0, 32'd0);
    send_order(OP_MARKET, 1'b1, 32'd0, 32'd0, 32'd0);
    send_order(OP_CANCEL, 1'b0, 32'd0, 32'd0, 32'd2);
    send_order(OP_CANCEL, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    send_order(OP_CANCEL_ALT, 1'b0, 32'd0, 32'd0, 32'd0);
    send_order(OP_CANCEL_ALT, 1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_order(OP_LIMIT, 1'b1, 32'd60, 32'd2, 32'hAAAA_5555);
    send_order(OP_LIMIT, 1'b1, 32'd60, 32'd2, 32'h5555_AAAA);
    send_order(OP_LIMIT, 1'b0, 32'd70, 32'd3, 32'd0);
    send_order(OP_LIMIT, 1'b0, 32'd1, 32'd1, 32'd0);
    send_order(OP_MARKET, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0);
    wait_drained();
  endtask

  // Fills the book past its capacity, then sweeps it with market orders.
  task automatic test_full_book();
    for (int i = 0; i < BOOK_SLOTS + 2; i++) begin
      send_order(OP_LIMIT, i[0], i[0] ? 32'd5000 + i : 32'd100 + i, 32'd3, 32'd0);
    end
    send_order(OP_MARKET, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_order(OP_MARKET, 1'b1, 32'd0, 32'hFFFF_FFFF, 32'd0);
    wait_drained();
  endtask

  // Holds the receiver off while the sender keeps offering, so input stalls.
  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      begin
        for (int i = 0; i < 10; i++) send_random_order();
        wait_drained();
      end
    join
  endtask

  task automatic test_random(input int count, input int pct_in, input int pct_out);
    idle_pct_in = pct_in;
    idle_pct_out = pct_out;
    for (int i = 0; i < count; i++) send_random_order();
    wait_drained();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= OP_LIMIT;
    in_side      <= 1'b0;
    in_price     <= '0;
    in_quantity  <= '0;
    in_cancel_id <= '0;
    hold_out = 1'b0;
    error_count = 0;
    idle_pct_in = 0;
    idle_pct_out = 0;
    orders_seen = '0;
    trade_count = '0;
    arrival_count = '0;
    for (int i = 0; i < BOOK_SLOTS; i++) begin
      book_live[i] = 1'b0;
      book_side[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_book();
    test_backpressure();
    test_random(20, 0, 0);
    test_random(20, 45, 0);
    test_random(20, 0, 45);
    test_random(20, 21, 21);
    // Let any late stray result show up before the verdict.
    repeat (500) @(posedge clk);
    if (error_count == 0 && expected_fills.size() == 0) begin
      $display("limit_order_book_matcher verification clean");
    end else begin
      $display("limit_order_book_matcher verification failed");
    end
    $finish;
  end

  // Watchdog: a sweep of 64 trades costs about 66 searches.
  initial begin
    #200ms;
    $display("limit_order_book_matcher verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/lobm_pkg.sv
rtl/lobm_cell.sv
rtl/limit_order_book_matcher.sv
dv/tb_limit_order_book_matcher.sv
